FILE: hw/rtl/aesctr_pkg.sv
`timescale 1ns / 1ps
package aesctr_pkg;

  typedef enum logic [1:0] {
    ACT_GENERATE = 2'd0,
    ACT_RESEED   = 2'd1,
    ACT_REINIT   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_RSD_ISSUE,
    ST_RSD_WAIT
  } ctrl_state_e;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RseedBlocks = 3;
  localparam int unsigned RseedOffset = 48 - (4 + 32);   // first buffer byte of new key
  localparam logic [15:0] IntervalReset = 16'd64;
  localparam logic [1:0] LastSlot = 2'd2;

  // one pipeline stage of the round chain
  typedef struct packed {
    logic         valid;
    logic         rsd;       // reseed block, not shown at the output
    logic [1:0]   slot;      // reseed block index
    logic         last;
    logic         reseeded;
    logic [127:0] state;     // byte j at bits 8j+7:8j
    logic [255:0] win;       // eight most recent key schedule words
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // column bytes: a0 in bits 7:0
  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[7:0];
    a1 = a[15:8];
    a2 = a[23:16];
    a3 = a[31:24];
    mix_col[7:0]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
    mix_col[15:8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
    mix_col[23:16] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
    mix_col[31:24] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
  endfunction

endpackage

FILE: hw/rtl/aesctr_round_cell.sv
`timescale 1ns / 1ps
module aesctr_round_cell import aesctr_pkg::*; #(
  parameter int unsigned ROUND = 1
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  localparam logic [7:0] Rcon = 8'h01 << ((ROUND / 2) - 1);

  stage_t       stage_d, stage_q;
  logic [127:0] sub_shift;
  logic [127:0] mixed;
  logic [127:0] round_key;
  logic [255:0] win_next;
  logic [31:0]  temp;
  logic [31:0]  nw [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sub_shift[8*(j+4*c) +: 8] = SBOX[stage_i.state[8*(j + 4*((c + j) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mixed[32*c +: 32] = (ROUND != NumRounds) ? mix_col(sub_shift[32*c +: 32])
                                               : sub_shift[32*c +: 32];
    end
  end

  // key schedule: four new words per round from round two on
  always_comb begin
    temp = stage_i.win[255:224];
    if (ROUND % 2 == 0) begin
      temp = {SBOX[stage_i.win[231:224]], SBOX[stage_i.win[255:248]],
              SBOX[stage_i.win[247:240]], SBOX[stage_i.win[239:232]] ^ Rcon};
    end else begin
      temp = {SBOX[stage_i.win[255:248]], SBOX[stage_i.win[247:240]],
              SBOX[stage_i.win[239:232]], SBOX[stage_i.win[231:224]]};
    end
    nw[0] = stage_i.win[31:0] ^ temp;
    nw[1] = stage_i.win[63:32] ^ nw[0];
    nw[2] = stage_i.win[95:64] ^ nw[1];
    nw[3] = stage_i.win[127:96] ^ nw[2];
    if (ROUND == 1) begin
      round_key = stage_i.win[255:128];
      win_next  = stage_i.win;
    end else begin
      round_key = {nw[3], nw[2], nw[1], nw[0]};
      win_next  = {nw[3], nw[2], nw[1], nw[0], stage_i.win[255:128]};
    end
  end

  always_comb begin
    stage_d       = stage_i;
    stage_d.state = mixed ^ round_key;
    stage_d.win   = win_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/aes_ctr_random_generator_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                                       Direction
// input     in_valid_i/in_ready_o, action_i, key/ctr ent  in
// output    out_valid_o/out_ready_i, block_*_o, last_o    out
// config    cfg_we_i, cfg_wdata_i (reseed interval)       in
//
// A generate request issues one block per cycle, unless the output stalls, into a
// 15-register AES-256 round chain (initial key add plus one cell per round, key
// schedule carried along); requests follow back to back unless a reseed is due.
// A reseed issues 3 blocks, then waits for them to drain through the chain
// before the new key is loaded and the next item is taken.
// The whole chain holds while a result waits at the output. Reset clears the
// key, counter and request count and sets the interval to 64.
module aes_ctr_random_generator_unit import aesctr_pkg::*; #(
  parameter int unsigned BLOCKS_PER_REQUEST = 16,
  parameter int unsigned MIN_RESEED         = 1,
  parameter int unsigned MAX_RESEED         = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_entropy_0_i,
  input  logic [63:0] key_entropy_1_i,
  input  logic [63:0] key_entropy_2_i,
  input  logic [63:0] key_entropy_3_i,
  input  logic [31:0] counter_entropy_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] block_low_o,
  output logic [63:0] block_high_o,
  output logic        last_o,
  output logic        reseeded_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (BLOCKS_PER_REQUEST > 1) ? $clog2(BLOCKS_PER_REQUEST) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BLOCKS_PER_REQUEST - 1);

  ctrl_state_e  state_d, state_q;
  logic [255:0] key_d, key_q;
  logic [31:0]  ctr_d, ctr_q;
  logic [15:0]  req_cnt_d, req_cnt_q;
  logic [15:0]  interval_q;
  logic [IdxW-1:0] idx_q;
  logic [1:0]   slot_q;
  logic         did_q;
  logic [255:0] ent_key_q;
  logic [31:0]  ent_ctr_q;
  logic [127:0] rs_q [2];

  logic         en, in_fire, issue_gen, issue_rsd, issue_last, done;
  logic [15:0]  req_next;
  logic [383:0] rbuf;
  stage_t       s0_d, s0_q;
  stage_t       stg [NumRounds+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue_last = (idx_q == LastIdx);
  assign req_next   = req_cnt_q + 16'd1;
  assign done       = stg[NumRounds].valid && stg[NumRounds].rsd &&
                      (stg[NumRounds].slot == LastSlot);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (action_i)
            ACT_GENERATE: state_d = ST_GEN;
            ACT_RESEED:   state_d = ST_RSD_ISSUE;
            ACT_REINIT:   state_d = ST_RSD_ISSUE;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_GEN: begin
        if (en && issue_last) begin
          if (did_q) begin
            state_d = ST_RSD_ISSUE;
          end else if (in_fire) begin
            case (action_i)
              ACT_GENERATE: state_d = ST_GEN;
              ACT_RESEED:   state_d = ST_RSD_ISSUE;
              ACT_REINIT:   state_d = ST_RSD_ISSUE;
              default:      state_d = ST_IDLE;
            endcase
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RSD_ISSUE: begin
        if (en && slot_q == LastSlot) state_d = ST_RSD_WAIT;
      end
      ST_RSD_WAIT: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    issue_gen  = 1'b0;
    issue_rsd  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_GEN: begin
        issue_gen  = en;
        in_ready_o = en && issue_last && !did_q;
      end
      ST_RSD_ISSUE: issue_rsd = en;
      ST_RSD_WAIT: ;
      default: ;
    endcase
  end

  // reseed buffer: first encryption on top, third at the bottom
  assign rbuf = {rs_q[0], rs_q[1], stg[NumRounds].state};

  always_comb begin
    ctr_d     = ctr_q;
    key_d     = key_q;
    req_cnt_d = req_cnt_q;
    if (issue_gen || issue_rsd) ctr_d = ctr_q + 32'd1;
    if (in_fire && action_i == ACT_REINIT) begin
      ctr_d = '0;
      key_d = '0;
    end
    if (in_fire && action_i == ACT_GENERATE) req_cnt_d = req_next;
    if (done) begin
      ctr_d     = ctr_q ^ ent_ctr_q;
      key_d     = rbuf[8*RseedOffset +: 256] ^ ent_key_q;
      req_cnt_d = '0;
    end
  end

  // issue register: counter block with the first round key added
  always_comb begin
    s0_d.valid    = issue_gen || issue_rsd;
    s0_d.rsd      = issue_rsd;
    s0_d.slot     = slot_q;
    s0_d.last     = issue_last;
    s0_d.reseeded = issue_last && did_q;
    s0_d.state    = issue_rsd ? ({4{ctr_q + 32'd1}} ^ key_q[127:0])
                              : ({4{ctr_q}} ^ key_q[127:0]);
    s0_d.win      = key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      key_q      <= '0;
      ctr_q      <= '0;
      req_cnt_q  <= '0;
      interval_q <= IntervalReset;
      idx_q      <= '0;
      slot_q     <= '0;
      did_q      <= 1'b0;
      s0_q.valid <= 1'b0;
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      ctr_q     <= ctr_d;
      req_cnt_q <= req_cnt_d;
      if (cfg_we_i) begin
        if (cfg_wdata_i < 16'(MIN_RESEED)) interval_q <= 16'(MIN_RESEED);
        else if (cfg_wdata_i > 16'(MAX_RESEED)) interval_q <= 16'(MAX_RESEED);
        else interval_q <= cfg_wdata_i;
      end
      if (issue_gen) idx_q <= issue_last ? '0 : idx_q + 1'b1;
      if (issue_rsd) slot_q <= (slot_q == LastSlot) ? 2'd0 : slot_q + 2'd1;
      if (in_fire && action_i == ACT_GENERATE) did_q <= (req_next >= interval_q);
      if (en) s0_q <= s0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ent_key_q <= {key_entropy_3_i, key_entropy_2_i, key_entropy_1_i, key_entropy_0_i};
      ent_ctr_q <= counter_entropy_i;
    end
    if (stg[NumRounds].valid && stg[NumRounds].rsd && stg[NumRounds].slot == 2'd0) begin
      rs_q[0] <= stg[NumRounds].state;
    end
    if (stg[NumRounds].valid && stg[NumRounds].rsd && stg[NumRounds].slot == 2'd1) begin
      rs_q[1] <= stg[NumRounds].state;
    end
  end

  assign stg[0] = s0_q;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aesctr_round_cell #(.ROUND(r)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stg[r-1]),
      .stage_o (stg[r])
    );
  end

  assign out_valid_o  = stg[NumRounds].valid && !stg[NumRounds].rsd;
  assign block_low_o  = stg[NumRounds].state[63:0];
  assign block_high_o = stg[NumRounds].state[127:64];
  assign last_o       = stg[NumRounds].last;
  assign reseeded_o   = stg[NumRounds].reseeded;

  a_no_accept_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RSD_WAIT) |-> !in_ready_o)
    else $error("input taken while reseed drains");

  a_reseeded_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reseeded_o) |-> last_o)
    else $error("reseeded flag off the last block");

  a_interval_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    interval_q != 16'd0)
    else $error("reseed interval is zero");

  a_rsd_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_q.valid && s0_q.rsd |-> s0_q.slot != 2'd3)
    else $error("bad reseed slot");

endmodule

FILE: dv/aes_ctr_checker.sv
`timescale 1ns / 1ps
module aes_ctr_checker import aesctr_pkg::*; #(
  parameter int unsigned BLOCKS_PER_REQUEST = 16,
  parameter int unsigned MIN_RESEED         = 1,
  parameter int unsigned MAX_RESEED         = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_entropy_0_i,
  input  logic [63:0] key_entropy_1_i,
  input  logic [63:0] key_entropy_2_i,
  input  logic [63:0] key_entropy_3_i,
  input  logic [31:0] counter_entropy_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic        last_i,
  input  logic        reseeded_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          errors_o,
  output int          pending_o,
  output int          blocks_o
);

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
    logic        reseeded;
  } block_t;

  logic [7:0]  sb [256];
  logic [255:0] key_q;
  logic [31:0]  ctr_q;
  logic [15:0]  req_cnt_q;
  logic [15:0]  interval_q;
  block_t       exp_blocks [$];

  initial begin
    for (int i = 0; i < 256; i++) sb[i] = SBOX[i];
  end

  function automatic logic [7:0] dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // key and data are little-endian byte vectors: byte j at bits 8j+7:8j
  function automatic logic [127:0] encrypt(logic [255:0] key, logic [127:0] din);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] x, a0, a1, a2, a3;
    logic [7:0] rc [8];
    logic [127:0] res;
    rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    for (int i = 0; i < 32; i++) rk[i] = key[8*i +: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if ((i & 7) == 0) begin
        x = w[0];
        w[0] = sb[w[1]] ^ rc[(i >> 3) & 7];
        w[1] = sb[w[2]];
        w[2] = sb[w[3]];
        w[3] = sb[x];
      end else if ((i & 7) == 4) begin
        for (int j = 0; j < 4; j++) w[j] = sb[w[j]];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-8)+j] ^ w[j];
    end
    for (int j = 0; j < 16; j++) s[j] = din[8*j +: 8] ^ rk[j];
    for (int r = 1; r <= 14; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[j+4*c] = sb[s[j + 4*((c+j) & 3)]];
      if (r != 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
          t[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
          t[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
          t[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end
      end
      for (int j = 0; j < 16; j++) s[j] = t[j] ^ rk[16*r+j];
    end
    for (int j = 0; j < 16; j++) res[8*j +: 8] = s[j];
    return res;
  endfunction

  task automatic refresh_key(logic [255:0] key_ent, logic [31:0] ctr_ent);
    logic [383:0] buf48;
    for (int b = 0; b < 3; b++) begin
      ctr_q = ctr_q + 1;
      buf48[(2-b)*128 +: 128] = encrypt(key_q, {4{ctr_q}});
    end
    key_q     = buf48[8*RseedOffset +: 256] ^ key_ent;
    ctr_q     = ctr_q ^ ctr_ent;
    req_cnt_q = '0;
  endtask

  task automatic take_request();
    logic [255:0] ent;
    logic [255:0] k;
    logic [127:0] o;
    block_t       b;
    int           first;
    ent = {key_entropy_3_i, key_entropy_2_i, key_entropy_1_i, key_entropy_0_i};
    case (action_i)
      ACT_RESEED: refresh_key(ent, counter_entropy_i);
      ACT_REINIT: begin
        key_q = '0;
        ctr_q = '0;
        refresh_key(ent, counter_entropy_i);
      end
      ACT_GENERATE: begin
        k = key_q;
        first = exp_blocks.size();
        for (int n = 0; n < BLOCKS_PER_REQUEST; n++) begin
          o = encrypt(k, {4{ctr_q}});
          ctr_q = ctr_q + 1;
          b.lo = o[63:0];
          b.hi = o[127:64];
          b.last = (n == BLOCKS_PER_REQUEST - 1);
          b.reseeded = 1'b0;
          exp_blocks.push_back(b);
        end
        req_cnt_q = req_cnt_q + 1;
        if (req_cnt_q >= interval_q) begin
          refresh_key(ent, counter_entropy_i);
          exp_blocks[first + BLOCKS_PER_REQUEST - 1].reseeded = 1'b1;
        end
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    block_t e;
    logic [15:0] v;
    if (!rst_ni) begin
      key_q      = '0;
      ctr_q      = '0;
      req_cnt_q  = '0;
      interval_q = IntervalReset;
      exp_blocks.delete();
      errors_o   = 0;
      blocks_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        blocks_o++;
        if (exp_blocks.size() == 0) begin
          $error("unexpected block transfer lo=%h", block_low_i);
          errors_o++;
        end else begin
          e = exp_blocks.pop_front();
          if (block_low_i !== e.lo) begin
            $error("block_low expected %h actual %h", e.lo, block_low_i);
            errors_o++;
          end
          if (block_high_i !== e.hi) begin
            $error("block_high expected %h actual %h", e.hi, block_high_i);
            errors_o++;
          end
          if (last_i !== e.last) begin
            $error("last expected %b actual %b", e.last, last_i);
            errors_o++;
          end
          if (reseeded_i !== e.reseeded) begin
            $error("reseeded expected %b actual %b", e.reseeded, reseeded_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) take_request();
      if (cfg_we_i) begin
        v = cfg_wdata_i;
        if (v < MIN_RESEED) v = MIN_RESEED;
        if (v > MAX_RESEED) v = MAX_RESEED;
        interval_q = v;
      end
    end
    pending_o = exp_blocks.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top import aesctr_pkg::*;;

  localparam int Watchdog = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_GENERATE;
  logic [63:0] key_entropy_0_i = '0, key_entropy_1_i = '0;
  logic [63:0] key_entropy_2_i = '0, key_entropy_3_i = '0;
  logic [31:0] counter_entropy_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] block_low_o, block_high_o;
  logic        last_o, reseeded_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  int          errors, pending, blocks;
  int          requests_sent = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  aes_ctr_random_generator_unit i_dut (.*);

  aes_ctr_checker i_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .key_entropy_0_i, .key_entropy_1_i, .key_entropy_2_i, .key_entropy_3_i,
    .counter_entropy_i, .out_valid_i(out_valid_o), .out_ready_i,
    .block_low_i(block_low_o), .block_high_i(block_high_o), .last_i(last_o),
    .reseeded_i(reseeded_o), .cfg_we_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending), .blocks_o(blocks)
  );

  // receiver: random stalls per block, or a long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        for (int i = 0; i < 150; i++) @(negedge clk_i);
        hold_off = 1'b0;
      end
      w = no_gaps ? 0 : $urandom_range(0, 4);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("watchdog expired, %0d blocks outstanding", pending);
      $display("aes_ctr_random_generator_unit: mismatch");
      $finish;
    end
  end

  // valid stays up after a transfer; it drops only before a gap or at idle_in
  task automatic send(logic [1:0] act, logic [63:0] e0, logic [63:0] e1,
                      logic [63:0] e2, logic [63:0] e3, logic [31:0] ce);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 4);
    if (w != 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    action_i          <= act;
    key_entropy_0_i   <= e0;
    key_entropy_1_i   <= e1;
    key_entropy_2_i   <= e2;
    key_entropy_3_i   <= e3;
    counter_entropy_i <= ce;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  task automatic idle_in();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_random(int gen_pct);
    int p;
    logic [1:0] act;
    p = $urandom_range(0, 99);
    if (p < gen_pct) act = ACT_GENERATE;
    else if (p < gen_pct + (100 - gen_pct) / 2) act = ACT_RESEED;
    else if (p < 97) act = ACT_REINIT;
    else act = 2'd3;
    send(act, rnd64(), rnd64(), rnd64(), rnd64(), $urandom());
  endtask

  // wait for drain, then cover the reseed drain latency before a write
  task automatic write_interval(logic [15:0] v);
    idle_in();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset key, field extremes, every action, unused code
    send(ACT_GENERATE, '0, '0, '0, '0, '0);
    send(ACT_RESEED, '1, '1, '1, '1, '1);
    send(ACT_GENERATE, '0, '0, '0, '0, '0);
    send(ACT_REINIT, '0, '0, '0, '0, '0);
    send(ACT_GENERATE, '1, '1, '1, '1, '1);
    send(2'd3, '1, '1, '1, '1, '1);
    send(ACT_REINIT, '1, '1, '1, '1, 32'hffff_ffff);
    // counter wraps during the next request
    send(ACT_REINIT, '0, '0, '0, '0, 32'hffff_fff8);
    send(ACT_GENERATE, '0, '0, '0, '0, '0);
    write_interval(16'd0);      // clamps to one: reseed after every request
    send(ACT_GENERATE, 64'h0123_4567_89ab_cdef, '1, '0, '1, 32'h8000_0001);
    send(ACT_GENERATE, '1, '0, '1, '0, 32'h7fff_fffe);
    write_interval(16'd2);
    for (int i = 0; i < 5; i++) send(ACT_GENERATE, rnd64(), rnd64(), rnd64(), rnd64(), $urandom());

    // back-pressure: receiver stops, sender keeps going
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send(ACT_GENERATE, rnd64(), rnd64(), rnd64(), rnd64(), $urandom());

    write_interval(16'hffff);
    for (int i = 0; i < 90; i++) send_random(60);
    write_interval(16'd3);
    no_gaps = 1'b1;
    for (int i = 0; i < 40; i++) send_random(70);
    no_gaps = 1'b0;
    write_interval(16'd1);
    for (int i = 0; i < 60; i++) send_random(65);
    write_interval(16'd64);
    for (int i = 0; i < 90; i++) send_random(80);
    idle_in();

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("sent %0d requests, checked %0d blocks over intervals 1, 2, 3, 64, 65535",
             requests_sent, blocks);
    if (errors == 0 && pending == 0) begin
      $display("aes_ctr_random_generator_unit: match");
    end else begin
      $display("aes_ctr_random_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
